>>> design/fp4_microscaled_row_dequantizer_core_defines.svh
// assertion macros for the fp4 row dequantizer checker
// expects signals clk and rst_n in the scope of use
`ifndef FP4_MICROSCALED_ROW_DEQUANTIZER_CORE_DEFINES_SVH
`define FP4_MICROSCALED_ROW_DEQUANTIZER_CORE_DEFINES_SVH

// same-cycle implication, held off while in reset
`define FP4DQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fp4dq check failed");

// next-cycle implication, held off while in reset
`define FP4DQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fp4dq check failed");

`endif

>>> design/fp4dq_pkg.sv
// shared constants for the fp4 microscaled row dequantizer
// no dependencies
`default_nettype none

package fp4dq_pkg;

    localparam int ROW_COUNT_BITS_DEF = 24;
    localparam int CFG_DATA_W         = 24;

    localparam logic [5:0] MX_BLOCK_BYTES = 6'd17;
    localparam logic [5:0] NV_BLOCK_BYTES = 6'd36;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    // configuration register indexes
    localparam logic CFG_FORMAT_MODE = 1'b0;
    localparam logic CFG_ROW_LENGTH  = 1'b1;

    localparam logic [23:0] ROW_LENGTH_RST = 24'd32;

endpackage

`default_nettype wire

>>> design/fp4dq_in_if.sv
// input channel: one packed row byte per word
// no dependencies
`default_nettype none

interface fp4dq_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] raw_byte;

    modport source (output valid, output raw_byte, input ready);
    modport sink   (input valid, input raw_byte, output ready);
endinterface

`default_nettype wire

>>> design/fp4dq_out_if.sv
// result channel: one float32 element per word
// no dependencies
`default_nettype none

interface fp4dq_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] value_bits;
    logic        row_end;

    modport source (output valid, output value_bits, output row_end, input ready);
    modport sink   (input valid, input value_bits, input row_end, output ready);
endinterface

`default_nettype wire

>>> design/fp4_microscaled_row_dequantizer_core.sv
// fp4 microscaled row dequantizer, top level
// depends on fp4dq_pkg, fp4dq_in_if, fp4dq_out_if
//
// usage
//   in_ch carries the packed row one byte per word: scale bytes then data bytes,
//   17-byte blocks in mxfp4 mode, 36-byte blocks in nvfp4 mode
//   out_ch carries one float32 element per word, row_end on the row's last one
//   cfg_we/cfg_index/cfg_data write format_mode (index 0) and row_length (1),
//   only while the block is idle
//   a data byte's elements pass through the pending buffer and then the result
//   register, the upper nibble's element first
//   data bytes are paced by the single result port taking one element per
//   cycle while the receiver is ready; scale bytes and bytes past the row are
//   taken every cycle while the pending buffer has room
//   a two-entry pending buffer sits between the byte decode and the result
//   register, so a new byte is taken while the last element still waits
//   when the receiver stalls the result register holds and the pending
//   buffer fills, then in_ch.ready drops
//   reset clears block position, element count and both channels; format
//   goes to mxfp4 and row length to 32; scale bytes are undefined until written
`default_nettype none

module fp4_microscaled_row_dequantizer_core #(
    parameter int ROW_COUNT_BITS = fp4dq_pkg::ROW_COUNT_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    fp4dq_in_if.sink                             in_ch,
    fp4dq_out_if.source                          out_ch,
    input  wire logic                            cfg_we,
    input  wire logic                            cfg_index,
    input  wire logic [fp4dq_pkg::CFG_DATA_W-1:0] cfg_data
);

    typedef struct packed {
        logic [3:0] nib;
        logic       row_end;
        logic [7:0] scale;
        logic       mode;
    } pend_t;

    // configuration
    logic        mode_reg;
    logic [23:0] row_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            row_length_reg <= fp4dq_pkg::ROW_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fp4dq_pkg::CFG_FORMAT_MODE: mode_reg       <= cfg_data[0];
                fp4dq_pkg::CFG_ROW_LENGTH:  row_length_reg <= cfg_data[23:0];
                default:                    mode_reg       <= mode_reg;
            endcase
        end
    end

    // block and row state
    logic [5:0]                byte_pos_reg, byte_pos_next;
    logic [ROW_COUNT_BITS-1:0] elem_cnt_reg, elem_cnt_next;
    logic [7:0]                scale_mem [4];

    logic [1:0] pend_cnt_reg, pend_cnt_next;
    pend_t      pend_reg [2];
    pend_t      pend_next [2];

    logic        out_valid_reg, out_valid_next;
    logic [31:0] value_reg;
    logic        row_end_reg;

    logic accept, move;

    assign move   = (pend_cnt_reg != 2'd0) && (!out_valid_reg || out_ch.ready);
    assign accept = in_ch.valid && in_ch.ready;

    assign in_ch.ready = (pend_cnt_reg == 2'd0) || ((pend_cnt_reg == 2'd1) && move);

    // byte decode
    logic [5:0]                blen, pos, d, pos_inc;
    logic                      is_scale;
    logic [ROW_COUNT_BITS-1:0] len, ec1, ec2;
    logic                      e1, e2, re1, re2;
    logic [7:0]                cur_scale;

    always_comb
    begin
        blen     = mode_reg ? fp4dq_pkg::NV_BLOCK_BYTES : fp4dq_pkg::MX_BLOCK_BYTES;
        pos      = (byte_pos_reg >= blen) ? 6'd0 : byte_pos_reg;
        is_scale = mode_reg ? (pos < 6'd4) : (pos == 6'd0);
        d        = pos - (mode_reg ? 6'd4 : 6'd1);
        len      = ROW_COUNT_BITS'(row_length_reg);
        cur_scale = mode_reg ? scale_mem[d[4:3]] : scale_mem[0];

        e1  = !is_scale && (elem_cnt_reg < len);
        ec1 = e1 ? elem_cnt_reg + 1'b1 : elem_cnt_reg;
        re1 = (ec1 == len);
        e2  = !is_scale && (ec1 < len);
        ec2 = e2 ? ec1 + 1'b1 : ec1;
        re2 = (ec2 == len);

        pos_inc = pos + 6'd1;
        if (pos_inc >= blen)
        begin
            byte_pos_next = 6'd0;
            elem_cnt_next = (ec2 >= len) ? '0 : ec2;
        end
        else
        begin
            byte_pos_next = pos_inc;
            elem_cnt_next = ec2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_scale)
        begin
            scale_mem[pos[1:0]] <= in_ch.raw_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg <= '0;
            elem_cnt_reg <= '0;
        end
        else if (accept)
        begin
            byte_pos_reg <= byte_pos_next;
            elem_cnt_reg <= elem_cnt_next;
        end
    end

    // pending buffer, front entry in slot 0
    always_comb
    begin
        pend_cnt_next = pend_cnt_reg;
        pend_next[0]  = pend_reg[0];
        pend_next[1]  = pend_reg[1];
        if (move)
        begin
            pend_next[0]  = pend_reg[1];
            pend_cnt_next = pend_cnt_reg - 2'd1;
        end
        if (accept && e1)
        begin
            pend_next[0]  = '{nib: in_ch.raw_byte[7:4], row_end: re1,
                              scale: cur_scale, mode: mode_reg};
            pend_next[1]  = '{nib: in_ch.raw_byte[3:0], row_end: re2,
                              scale: cur_scale, mode: mode_reg};
            pend_cnt_next = e2 ? 2'd2 : 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg[0] <= pend_next[0];
        pend_reg[1] <= pend_next[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt_reg <= 2'd0;
        end
        else
        begin
            pend_cnt_reg <= pend_cnt_next;
        end
    end

    // element times scale, exact unless it overflows
    pend_t              f;
    logic [3:0]         h, s_man;
    logic signed [8:0]  s_k;
    logic               s_inf, s_zero, sgn;
    logic [4:0]         ex;
    logic [7:0]         prod, norm;
    logic [2:0]         p;
    logic signed [10:0] bexp, sh;
    logic [31:0]        value_next;

    always_comb
    begin
        f   = pend_reg[0];
        sgn = f.nib[3];
        unique case (f.nib[2:0])
            3'd0:    h = 4'd0;
            3'd1:    h = 4'd1;
            3'd2:    h = 4'd2;
            3'd3:    h = 4'd3;
            3'd4:    h = 4'd4;
            3'd5:    h = 4'd6;
            3'd6:    h = 4'd8;
            3'd7:    h = 4'd12;
            default: h = 4'd0;
        endcase

        ex     = f.scale[7:3];
        s_inf  = 1'b0;
        s_zero = 1'b0;
        if (!f.mode)
        begin
            s_man = 4'd1;
            s_k   = $signed({1'b0, f.scale}) - 9'sd127;
            s_inf = (f.scale == 8'hFF);
        end
        else if (ex == 5'd0)
        begin
            s_man = {1'b0, f.scale[2:0]};
            s_k   = -9'sd6;
        end
        else
        begin
            s_man  = {1'b1, f.scale[2:0]};
            s_k    = $signed({4'b0, ex}) - 9'sd10;
            s_zero = (ex == 5'h1F);
        end

        prod = {4'd0, h} * {4'd0, s_man};
        p    = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (prod[i])
            begin
                p = 3'(i);
            end
        end
        bexp = 11'(s_k) + 11'sd126 + $signed({8'b0, p});
        sh   = 11'(s_k) + 11'sd148;
        norm = prod << (3'd7 - p);

        if (s_inf)
        begin
            value_next = (h == 4'd0) ? fp4dq_pkg::CANON_NAN : {sgn, 8'hFF, 23'd0};
        end
        else if (s_zero || prod == 8'd0)
        begin
            value_next = {sgn, 31'd0};
        end
        else if (bexp > 11'sd254)
        begin
            value_next = {sgn, 8'hFF, 23'd0};
        end
        else if (bexp <= 11'sd0)
        begin
            value_next = {sgn, 31'({23'd0, prod} << sh[4:0])};
        end
        else
        begin
            value_next = {sgn, bexp[7:0], norm[6:0], 16'd0};
        end
    end

    // result register
    assign out_valid_next = move ? 1'b1 : (out_valid_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            value_reg   <= value_next;
            row_end_reg <= f.row_end;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.value_bits = value_reg;
    assign out_ch.row_end    = row_end_reg;

endmodule

`default_nettype wire

>>> design/fp4dq_checker.sv
// port-level checks for the fp4 row dequantizer, bound to the top level
// depends on fp4dq_pkg and the defines header
`default_nettype none

`include "fp4_microscaled_row_dequantizer_core_defines.svh"

module fp4dq_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] value_bits,
    input wire logic        row_end
);

    // a stalled word holds
    `FP4DQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(value_bits) && $stable(row_end))

    // any nan leaves in canonical form
    `FP4DQ_ASSERT_NOW(a_nan_canon,
        out_valid && value_bits[30:23] == 8'hFF && value_bits[22:0] != 23'd0,
        value_bits == fp4dq_pkg::CANON_NAN)

    // input back-pressure only while results are pending, so a word follows
    `FP4DQ_ASSERT_NEXT(a_stall_has_word, !in_ready, out_valid)

endmodule

bind fp4_microscaled_row_dequantizer_core fp4dq_checker u_fp4dq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .value_bits (out_ch.value_bits),
    .row_end    (out_ch.row_end)
);

`default_nettype wire
